/* rtl/protobuf_wire_tokenizer_assert.svh */
// assertion macros for the protobuf wire tokenizer
`ifndef PROTOBUF_WIRE_TOKENIZER_ASSERT_SVH
`define PROTOBUF_WIRE_TOKENIZER_ASSERT_SVH

// checked only out of reset
`define PWT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked also while reset is held
`define PWT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/pwt_pkg.sv */
// package: types, codes and constants of the protobuf wire tokenizer
`default_nettype none
package pwt_pkg;

    localparam int LENGTH_BITS       = 32;
    localparam int VARINT_LIMIT_BITS = 64;
    localparam int VARINT_MAX_BYTES  = (VARINT_LIMIT_BITS + 6) / 7;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] TK_VARINT  = 3'd0;
    localparam logic [2:0] TK_FIXED   = 3'd1;
    localparam logic [2:0] TK_HEADER  = 3'd2;
    localparam logic [2:0] TK_PAYLOAD = 3'd3;
    localparam logic [2:0] TK_ERROR   = 3'd4;

    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_TRUNC_VARINT = 3'd1;
    localparam logic [2:0] ERR_OVERLONG     = 3'd2;
    localparam logic [2:0] ERR_BAD_WIRE     = 3'd3;
    localparam logic [2:0] ERR_TRUNC_FIXED  = 3'd4;
    localparam logic [2:0] ERR_TRUNC_MSG    = 3'd5;

    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_I64    = 3'd1;
    localparam logic [2:0] WT_LEN    = 3'd2;
    localparam logic [2:0] WT_I32    = 3'd5;

    typedef enum logic [2:0] {
        PH_TAG,
        PH_VARINT,
        PH_FIXED,
        PH_LENGTH,
        PH_PAYLOAD
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } req_t;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [31:0] field_number;
        logic [2:0]  wire_kind;
        logic [63:0] field_value;
        logic        payload_end;
        logic [2:0]  error_code;
        logic        buffer_end;
    } tok_t;

    // classified byte as held in the queue
    typedef struct packed {
        logic       cont;
        logic [6:0] low7;
        logic       last;
    } byte_t;

endpackage
`default_nettype wire

/* rtl/pwt_front.sv */
// front end: accepts request bytes, classifies them and queues them for the parser
`default_nettype none
`include "protobuf_wire_tokenizer_assert.svh"
module pwt_front
    import pwt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  req_valid,
    output logic       req_ready,
    input  wire req_t  req_data,
    output logic       q_valid,
    input  wire logic  q_ready,
    output byte_t      q_data
);

    byte_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_next;
    logic [QUEUE_CW-1:0]  cnt_reg;
    logic [QUEUE_CW-1:0]  cnt_next;
    logic                 push;
    logic                 pop;
    byte_t                entry;

    assign req_ready = (cnt_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign q_valid   = (cnt_reg != '0);
    assign q_data    = mem_reg[rd_ptr_reg];
    assign push      = req_valid && req_ready;
    assign pop       = q_valid && q_ready;

    // split off the continuation bit
    always_comb
    begin
        entry.cont = req_data.data_byte[7];
        entry.low7 = req_data.data_byte[6:0];
        entry.last = req_data.last_byte;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QUEUE_AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QUEUE_AW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QUEUE_CW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= entry;
        end
    end

    `PWT_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> cnt_reg == '0, "queue not empty in reset")
    `PWT_ASSERT(a_cnt_bound, cnt_reg <= QUEUE_CW'(QUEUE_DEPTH), "queue count overflow")
    `PWT_ASSERT(a_ptr_track, (cnt_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg), "empty ptr mismatch")

endmodule
`default_nettype wire

/* rtl/pwt_parser.sv */
// back end: wire-format parse state machine and token output register
`default_nettype none
`include "protobuf_wire_tokenizer_assert.svh"
module pwt_parser
    import pwt_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   q_valid,
    output logic        q_ready,
    input  wire byte_t  q_data,
    output logic        tok_valid,
    input  wire logic   tok_ready,
    output tok_t        tok_data
);

    phase_t                  phase_reg;
    phase_t                  phase_next;
    logic [63:0]             acc_reg;
    logic [63:0]             acc_next;
    logic [3:0]              cnt_reg;
    logic [3:0]              cnt_next;
    logic [LENGTH_BITS-1:0]  rem_reg;
    logic [LENGTH_BITS-1:0]  rem_next;
    logic [31:0]             field_reg;
    logic [31:0]             field_next;
    logic [2:0]              wire_reg;
    logic [2:0]              wire_next;
    logic                    hold_reg;
    logic                    hold_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    tok_t                    out_reg;

    logic                    step;
    logic                    produce;
    logic                    fail;
    logic [2:0]              fail_code;
    tok_t                    res;
    logic                    fin;
    logic [3:0]              cnt_inc;
    logic [6:0]              sh7;
    logic [5:0]              sh8;
    logic [63:0]             vacc;
    logic [63:0]             facc;
    logic [3:0]              need;
    logic                    overlong;
    logic [LENGTH_BITS-1:0]  rem_dec;

    assign q_ready   = !out_valid_reg || tok_ready;
    assign step      = q_valid && q_ready;
    assign tok_valid = out_valid_reg;
    assign tok_data  = out_reg;

    assign fin      = q_data.last;
    assign cnt_inc  = cnt_reg + 4'd1;
    assign sh7      = {cnt_reg, 3'b000} - 7'(cnt_reg);
    assign sh8      = {cnt_reg[2:0], 3'b000};
    assign vacc     = acc_reg | (64'(q_data.low7) << sh7);
    assign facc     = acc_reg | (64'({q_data.cont, q_data.low7}) << sh8);
    assign need     = (wire_reg == WT_I64) ? 4'd8 : 4'd4;
    assign overlong = q_data.cont && (cnt_inc >= 4'(VARINT_MAX_BYTES));
    assign rem_dec  = rem_reg - LENGTH_BITS'(rem_reg != '0);

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        field_next = field_reg;
        wire_next  = wire_reg;
        hold_next  = hold_reg;
        produce    = 1'b0;
        fail       = 1'b0;
        fail_code  = ERR_NONE;

        res.token_kind   = TK_VARINT;
        res.field_number = field_reg;
        res.wire_kind    = wire_reg;
        res.field_value  = vacc;
        res.payload_end  = 1'b0;
        res.error_code   = ERR_NONE;
        res.buffer_end   = fin;

        if (!hold_reg)
        begin
            unique case (phase_reg)
                PH_TAG:
                begin
                    acc_next = vacc;
                    cnt_next = cnt_inc;
                    if (overlong)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_OVERLONG;
                    end
                    else if (q_data.cont)
                    begin
                        fail      = fin;
                        fail_code = ERR_TRUNC_VARINT;
                    end
                    else
                    begin
                        field_next       = vacc[34:3];
                        wire_next        = vacc[2:0];
                        res.field_number = vacc[34:3];
                        res.wire_kind    = vacc[2:0];
                        acc_next         = '0;
                        cnt_next         = '0;
                        priority if (vacc[2:0] == WT_VARINT || vacc[2:0] == WT_LEN)
                        begin
                            phase_next = (vacc[2:0] == WT_VARINT) ? PH_VARINT : PH_LENGTH;
                            fail       = fin;
                            fail_code  = ERR_TRUNC_VARINT;
                        end
                        else if (vacc[2:0] == WT_I64 || vacc[2:0] == WT_I32)
                        begin
                            phase_next = PH_FIXED;
                            fail       = fin;
                            fail_code  = ERR_TRUNC_FIXED;
                        end
                        else
                        begin
                            fail      = 1'b1;
                            fail_code = ERR_BAD_WIRE;
                        end
                    end
                end
                PH_VARINT, PH_LENGTH:
                begin
                    acc_next = vacc;
                    cnt_next = cnt_inc;
                    if (overlong)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_OVERLONG;
                    end
                    else if (q_data.cont)
                    begin
                        fail      = fin;
                        fail_code = ERR_TRUNC_VARINT;
                    end
                    else if (phase_reg == PH_VARINT)
                    begin
                        produce    = 1'b1;
                        phase_next = PH_TAG;
                        acc_next   = '0;
                        cnt_next   = '0;
                    end
                    else if (((vacc >> LENGTH_BITS) != '0) || (fin && vacc != '0))
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_TRUNC_MSG;
                    end
                    else
                    begin
                        produce         = 1'b1;
                        res.token_kind  = TK_HEADER;
                        res.payload_end = (vacc == '0);
                        acc_next        = '0;
                        cnt_next        = '0;
                        rem_next        = vacc[LENGTH_BITS-1:0];
                        phase_next      = (vacc == '0) ? PH_TAG : PH_PAYLOAD;
                    end
                end
                PH_FIXED:
                begin
                    acc_next = facc;
                    cnt_next = cnt_inc;
                    if (cnt_inc < need)
                    begin
                        fail      = fin;
                        fail_code = ERR_TRUNC_FIXED;
                    end
                    else
                    begin
                        produce         = 1'b1;
                        res.token_kind  = TK_FIXED;
                        res.field_value = facc;
                        phase_next      = PH_TAG;
                        acc_next        = '0;
                        cnt_next        = '0;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (fin && rem_reg > LENGTH_BITS'(1))
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_TRUNC_MSG;
                    end
                    else
                    begin
                        produce         = 1'b1;
                        res.token_kind  = TK_PAYLOAD;
                        res.field_value = 64'({q_data.cont, q_data.low7});
                        res.payload_end = (rem_dec == '0);
                        rem_next        = rem_dec;
                        if (rem_dec == '0)
                        begin
                            phase_next = PH_TAG;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_TAG;
                end
            endcase
        end

        if (fail)
        begin
            produce         = 1'b1;
            res.token_kind  = TK_ERROR;
            res.field_value = '0;
            res.payload_end = 1'b0;
            res.error_code  = fail_code;
            hold_next       = 1'b1;
        end

        // every final byte starts a new buffer
        if (fin)
        begin
            phase_next = PH_TAG;
            acc_next   = '0;
            cnt_next   = '0;
            rem_next   = '0;
            field_next = '0;
            wire_next  = '0;
            hold_next  = 1'b0;
        end

        if (step && produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (tok_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TAG;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            field_reg     <= '0;
            wire_reg      <= '0;
            hold_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (step)
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                cnt_reg   <= cnt_next;
                rem_reg   <= rem_next;
                field_reg <= field_next;
                wire_reg  <= wire_next;
                hold_reg  <= hold_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && produce)
        begin
            out_reg <= res;
        end
    end

    `PWT_ASSERT(a_err_clean, (tok_valid && tok_data.token_kind == TK_ERROR) |-> (tok_data.field_value == '0 && !tok_data.payload_end), "error token carries data")
    `PWT_ASSERT(a_hold_err, $rose(hold_reg) |-> (tok_valid && tok_data.token_kind == TK_ERROR && !tok_data.buffer_end), "hold without error token")
    `PWT_ASSERT(a_payload_rem, (phase_reg == PH_PAYLOAD) |-> (rem_reg != '0), "payload phase with nothing left")
    `PWT_ASSERT(a_fixed_cnt, (phase_reg == PH_FIXED) |-> (cnt_reg < 4'd8), "fixed byte count overrun")

endmodule
`default_nettype wire

/* rtl/protobuf_wire_tokenizer.sv */
// path: an accepted byte is written to the queue; its parse step then registers the token
// throughput: one byte per cycle, set by the back-end parse step, unless tok_ready stalls
// a two-entry queue parts the front end from the parser, an output register holds tokens
// bytes that end a field part-way give no token unless final (error); at most one per byte
// reset: asynchronous, active low; clears queue, parse state and output valid
`default_nettype none
module protobuf_wire_tokenizer
    import pwt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  req_valid,
    output logic       req_ready,
    input  wire req_t  req_data,
    output logic       tok_valid,
    input  wire logic  tok_ready,
    output tok_t       tok_data
);

    logic   q_valid;
    logic   q_ready;
    byte_t  q_data;

    pwt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data)
    );

    pwt_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_data  (tok_data)
    );

endmodule
`default_nettype wire
